/* rtl/pst_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and helpers of the priority schedule timing block.
// Used by pst_ctrl, pst_dpath, the top level and the port checker.
package pst_pkg;

    localparam int MAX_PROCS = 16;
    localparam int FRAC_BITS = 8;

    localparam int CNT_W   = $clog2(MAX_PROCS + 1);
    localparam int IDX_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int ID_W    = 5;
    localparam int TIME_W  = 20;
    localparam int TOT_W   = 24;
    localparam int AVG_W   = 28;
    localparam int DIVD_W  = TOT_W + FRAC_BITS;
    localparam int DCNT_W  = $clog2(DIVD_W);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_FIELD_W = ID_W + PRIO_W + BURST_W + 2 * TIME_W + 2 * AVG_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [TOT_W-1:0]  TOT_MAX  = {TOT_W{1'b1}};
    localparam logic [AVG_W-1:0]  AVG_MAX  = {AVG_W{1'b1}};

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_COMMIT,
        ST_DIV_INIT,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic sort_start;
        logic scan;
        logic commit;
        logic div_start;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic rank_last;
        logic div_last;
        logic emit_last;
        logic out_free;
    } status_t;

    function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] a,
                                                   input logic [BURST_W-1:0] b);
        logic [TIME_W:0] s;
        begin
            s = {1'b0, a} + (TIME_W + 1)'(b);
            sat_time = s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
        end
    endfunction

    function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
        logic [TOT_W:0] s;
        begin
            s = {1'b0, a} + (TOT_W + 1)'(b);
            sat_tot = s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
        end
    endfunction

    function automatic logic [AVG_W-1:0] sat_avg(input logic [DIVD_W-1:0] q);
        logic [63:0] q64;
        begin
            q64 = 64'(q);
            sat_avg = (q64 > 64'(AVG_MAX)) ? AVG_MAX : q64[AVG_W-1:0];
        end
    endfunction

endpackage

/* rtl/priority_schedule_timing_top.sv */
`timescale 1ns / 1ps
// Non-preemptive priority scheduler for one batch of jobs at a time.
// Instantiates pst_ctrl and pst_dpath; types and widths from pst_pkg.
//
// Usage: stream jobs in on s_axis (burst and priority in tdata, tlast on the
// final job of a batch). Jobs are taken one per cycle while loading; jobs past
// MAX_PROCS are dropped and flag overflow in tuser of every result. After the
// tlast beat, s_axis_tready stays low while the batch is ordered and timed:
// one selection scan over the n stored jobs per run slot (one store entry
// read per cycle), then the two means in a restoring divider: a start step,
// then one quotient bit per cycle. Results then leave on m_axis in run order,
// one per cycle when the receiver is ready, tlast on the final one.
// The result sits in an output register; a stalled receiver holds it and
// freezes the emit sequence. The next batch loads while the last result of
// the previous one still waits. Reset empties the batch and clears m_axis_tvalid.
module priority_schedule_timing_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pst_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // in_burst, in_priority
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // process_id, run_priority, run_burst, completion_time, waiting_time,
    // avg_turnaround, avg_waiting, zero fill
    output logic [pst_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser,  // overflow
    output logic                                m_axis_tlast
);

    pst_pkg::cmd_t    cmd;
    pst_pkg::status_t st;

    logic [pst_pkg::ID_W-1:0]    process_id;
    logic [pst_pkg::PRIO_W-1:0]  run_priority;
    logic [pst_pkg::BURST_W-1:0] run_burst;
    logic [pst_pkg::TIME_W-1:0]  completion_time;
    logic [pst_pkg::TIME_W-1:0]  waiting_time;
    logic [pst_pkg::AVG_W-1:0]   avg_turnaround;
    logic [pst_pkg::AVG_W-1:0]   avg_waiting;

    pst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .st       (st),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    pst_dpath u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .in_burst        (s_axis_tdata[15:0]),
        .in_priority     (s_axis_tdata[23:16]),
        .out_ready       (m_axis_tready),
        .st              (st),
        .out_valid       (m_axis_tvalid),
        .process_id      (process_id),
        .run_priority    (run_priority),
        .run_burst       (run_burst),
        .completion_time (completion_time),
        .waiting_time    (waiting_time),
        .avg_turnaround  (avg_turnaround),
        .avg_waiting     (avg_waiting),
        .overflow        (m_axis_tuser),
        .end_of_run      (m_axis_tlast)
    );

    assign m_axis_tdata = pst_pkg::OUT_TDATA_W'({avg_waiting, avg_turnaround, waiting_time,
                                                 completion_time, run_burst, run_priority,
                                                 process_id});

endmodule

/* rtl/pst_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the priority schedule timing block: load, selection scan,
// mean division and emit phases. Depends on pst_pkg.
module pst_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    input  pst_pkg::status_t st,
    output logic            in_ready,
    output pst_pkg::cmd_t   cmd
);

    pst_pkg::state_t state_reg;
    pst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pst_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            pst_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.sort_start = 1'b1;
                        state_next     = pst_pkg::ST_SCAN;
                    end
                end
            end
            pst_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_last)
                begin
                    state_next = pst_pkg::ST_COMMIT;
                end
            end
            pst_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = st.rank_last ? pst_pkg::ST_DIV_INIT : pst_pkg::ST_SCAN;
            end
            pst_pkg::ST_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = pst_pkg::ST_DIV;
            end
            pst_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = pst_pkg::ST_EMIT;
                end
            end
            pst_pkg::ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.emit_last)
                    begin
                        state_next = pst_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = pst_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

/* rtl/pst_dpath.sv */
`timescale 1ns / 1ps
// Datapath of the priority schedule timing block: job store, minimum-priority
// scan, time accumulators, restoring divider and output register. Uses pst_pkg.
module pst_dpath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pst_pkg::cmd_t                     cmd,
    input  logic [pst_pkg::BURST_W-1:0]       in_burst,
    input  logic [pst_pkg::PRIO_W-1:0]        in_priority,
    input  logic                              out_ready,
    output pst_pkg::status_t                  st,
    output logic                              out_valid,
    output logic [pst_pkg::ID_W-1:0]          process_id,
    output logic [pst_pkg::PRIO_W-1:0]        run_priority,
    output logic [pst_pkg::BURST_W-1:0]       run_burst,
    output logic [pst_pkg::TIME_W-1:0]        completion_time,
    output logic [pst_pkg::TIME_W-1:0]        waiting_time,
    output logic [pst_pkg::AVG_W-1:0]         avg_turnaround,
    output logic [pst_pkg::AVG_W-1:0]         avg_waiting,
    output logic                              overflow,
    output logic                              end_of_run
);

    logic [pst_pkg::BURST_W-1:0] burst_mem [pst_pkg::MAX_PROCS];
    logic [pst_pkg::PRIO_W-1:0]  prio_mem  [pst_pkg::MAX_PROCS];
    logic [pst_pkg::IDX_W-1:0]   order_reg [pst_pkg::MAX_PROCS];
    logic [pst_pkg::MAX_PROCS-1:0] taken_reg;

    logic [pst_pkg::CNT_W-1:0]   count_reg;
    logic                        dropped_reg;
    logic [pst_pkg::IDX_W-1:0]   scan_idx_reg;
    logic [pst_pkg::IDX_W-1:0]   rank_reg;
    logic [pst_pkg::IDX_W-1:0]   emit_idx_reg;
    logic                        best_valid_reg;
    logic [pst_pkg::IDX_W-1:0]   best_idx_reg;
    logic [pst_pkg::PRIO_W-1:0]  best_prio_reg;
    logic [pst_pkg::BURST_W-1:0] best_burst_reg;
    logic [pst_pkg::DCNT_W-1:0]  div_cnt_reg;
    logic                        out_valid_reg;

    logic [pst_pkg::TIME_W-1:0]  time_reg;
    logic [pst_pkg::TOT_W-1:0]   tot_t_reg;
    logic [pst_pkg::TOT_W-1:0]   tot_w_reg;
    logic [pst_pkg::TIME_W-1:0]  etime_reg;
    logic [pst_pkg::CNT_W-1:0]   rem_t_reg;
    logic [pst_pkg::CNT_W-1:0]   rem_w_reg;
    logic [pst_pkg::DIVD_W-1:0]  quo_t_reg;
    logic [pst_pkg::DIVD_W-1:0]  quo_w_reg;

    logic [pst_pkg::ID_W-1:0]    id_reg;
    logic [pst_pkg::PRIO_W-1:0]  prio_out_reg;
    logic [pst_pkg::BURST_W-1:0] burst_out_reg;
    logic [pst_pkg::TIME_W-1:0]  ct_out_reg;
    logic [pst_pkg::TIME_W-1:0]  wt_out_reg;
    logic [pst_pkg::AVG_W-1:0]   avg_t_reg;
    logic [pst_pkg::AVG_W-1:0]   avg_w_reg;
    logic                        ovf_reg;
    logic                        eor_reg;

    logic [pst_pkg::CNT_W-1:0]   count_m1;
    logic [pst_pkg::IDX_W-1:0]   emit_k;
    logic [pst_pkg::IDX_W-1:0]   rd_idx;
    logic [pst_pkg::BURST_W-1:0] rd_burst;
    logic [pst_pkg::PRIO_W-1:0]  rd_prio;
    logic                        better;
    logic [pst_pkg::TIME_W-1:0]  commit_ct;
    logic [pst_pkg::TIME_W-1:0]  emit_ct;
    logic [pst_pkg::CNT_W:0]     trial_t;
    logic [pst_pkg::CNT_W:0]     trial_w;
    logic [pst_pkg::CNT_W:0]     diff_t;
    logic [pst_pkg::CNT_W:0]     diff_w;

    assign count_m1 = count_reg - pst_pkg::CNT_W'(1);
    assign emit_k   = order_reg[emit_idx_reg];
    assign rd_idx   = cmd.emit ? emit_k : scan_idx_reg;
    assign rd_burst = burst_mem[rd_idx];
    assign rd_prio  = prio_mem[rd_idx];
    assign better   = !taken_reg[scan_idx_reg] && (!best_valid_reg || (rd_prio < best_prio_reg));

    assign commit_ct = pst_pkg::sat_time(time_reg, best_burst_reg);
    assign emit_ct   = pst_pkg::sat_time(etime_reg, rd_burst);

    assign trial_t = {rem_t_reg, quo_t_reg[pst_pkg::DIVD_W-1]};
    assign trial_w = {rem_w_reg, quo_w_reg[pst_pkg::DIVD_W-1]};
    assign diff_t  = trial_t - {1'b0, count_reg};
    assign diff_w  = trial_w - {1'b0, count_reg};

    assign st.scan_last = (pst_pkg::CNT_W'(scan_idx_reg) == count_m1);
    assign st.rank_last = (pst_pkg::CNT_W'(rank_reg) == count_m1);
    assign st.emit_last = (pst_pkg::CNT_W'(emit_idx_reg) == count_m1);
    assign st.div_last  = (div_cnt_reg == pst_pkg::DCNT_W'(pst_pkg::DIVD_W - 1));
    assign st.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            taken_reg      <= '0;
            scan_idx_reg   <= '0;
            rank_reg       <= '0;
            emit_idx_reg   <= '0;
            best_valid_reg <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (count_reg < pst_pkg::CNT_W'(pst_pkg::MAX_PROCS))
                begin
                    count_reg <= count_reg + pst_pkg::CNT_W'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.sort_start)
            begin
                taken_reg      <= '0;
                scan_idx_reg   <= '0;
                rank_reg       <= '0;
                emit_idx_reg   <= '0;
                best_valid_reg <= 1'b0;
            end
            if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + pst_pkg::IDX_W'(1);
                if (better)
                begin
                    best_valid_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                taken_reg[best_idx_reg] <= 1'b1;
                rank_reg       <= rank_reg + pst_pkg::IDX_W'(1);
                scan_idx_reg   <= '0;
                best_valid_reg <= 1'b0;
            end
            if (cmd.div_start)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + pst_pkg::DCNT_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                emit_idx_reg  <= emit_idx_reg + pst_pkg::IDX_W'(1);
                if (st.emit_last)
                begin
                    count_reg   <= '0;
                    dropped_reg <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < pst_pkg::CNT_W'(pst_pkg::MAX_PROCS)))
        begin
            burst_mem[count_reg[pst_pkg::IDX_W-1:0]] <= in_burst;
            prio_mem[count_reg[pst_pkg::IDX_W-1:0]]  <= in_priority;
        end
        if (cmd.sort_start)
        begin
            time_reg  <= '0;
            tot_t_reg <= '0;
            tot_w_reg <= '0;
            etime_reg <= '0;
        end
        if (cmd.scan && better)
        begin
            best_idx_reg   <= scan_idx_reg;
            best_prio_reg  <= rd_prio;
            best_burst_reg <= rd_burst;
        end
        if (cmd.commit)
        begin
            order_reg[rank_reg] <= best_idx_reg;
            time_reg  <= commit_ct;
            tot_t_reg <= pst_pkg::sat_tot(tot_t_reg, commit_ct);
            tot_w_reg <= pst_pkg::sat_tot(tot_w_reg,
                                          commit_ct - pst_pkg::TIME_W'(best_burst_reg));
        end
        if (cmd.div_start)
        begin
            rem_t_reg <= '0;
            rem_w_reg <= '0;
            quo_t_reg <= pst_pkg::DIVD_W'(tot_t_reg) << pst_pkg::FRAC_BITS;
            quo_w_reg <= pst_pkg::DIVD_W'(tot_w_reg) << pst_pkg::FRAC_BITS;
        end
        else if (cmd.div_step)
        begin
            rem_t_reg <= diff_t[pst_pkg::CNT_W] ? trial_t[pst_pkg::CNT_W-1:0]
                                                : diff_t[pst_pkg::CNT_W-1:0];
            rem_w_reg <= diff_w[pst_pkg::CNT_W] ? trial_w[pst_pkg::CNT_W-1:0]
                                                : diff_w[pst_pkg::CNT_W-1:0];
            quo_t_reg <= {quo_t_reg[pst_pkg::DIVD_W-2:0], !diff_t[pst_pkg::CNT_W]};
            quo_w_reg <= {quo_w_reg[pst_pkg::DIVD_W-2:0], !diff_w[pst_pkg::CNT_W]};
        end
        if (cmd.emit)
        begin
            etime_reg     <= emit_ct;
            id_reg        <= pst_pkg::ID_W'(pst_pkg::ID_W'(emit_k) + pst_pkg::ID_W'(1));
            prio_out_reg  <= rd_prio;
            burst_out_reg <= rd_burst;
            ct_out_reg    <= emit_ct;
            wt_out_reg    <= emit_ct - pst_pkg::TIME_W'(rd_burst);
            avg_t_reg     <= pst_pkg::sat_avg(quo_t_reg);
            avg_w_reg     <= pst_pkg::sat_avg(quo_w_reg);
            ovf_reg       <= dropped_reg;
            eor_reg       <= st.emit_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign process_id      = id_reg;
    assign run_priority    = prio_out_reg;
    assign run_burst       = burst_out_reg;
    assign completion_time = ct_out_reg;
    assign waiting_time    = wt_out_reg;
    assign avg_turnaround  = avg_t_reg;
    assign avg_waiting     = avg_w_reg;
    assign overflow        = ovf_reg;
    assign end_of_run      = eor_reg;

endmodule

/* rtl/pst_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for priority_schedule_timing_top, bound to the top level.
// Depends on pst_pkg for port widths.
module pst_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken right after end of batch");

    a_wait_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (20'(m_axis_tdata[68:49] + m_axis_tdata[28:13]) == m_axis_tdata[48:29]))
        else $error("waiting plus burst differs from completion");

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:0] != 5'd0))
        else $error("zero process id");

endmodule

bind priority_schedule_timing_top pst_checker u_pst_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench of priority_schedule_timing_top: streams batches of jobs and
// checks every scheduled result against a batch scheduler kept in the bench.
// Depends on pst_pkg and the RTL under rtl/.
module tb_top;

    import pst_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PARK_CYCLES = 600;
    localparam int RANDOM_ITEMS = 330;
    localparam int FILL_W = OUT_TDATA_W - OUT_FIELD_W;

    typedef struct {
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [ID_W-1:0]    id;
    } job_t;

    typedef struct {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  completion;
        logic [TIME_W-1:0]  waiting;
        logic [AVG_W-1:0]   avg_turn;
        logic [AVG_W-1:0]   avg_wait;
        logic               dropped;
        logic               batch_end;
    } run_slot_t;

    typedef struct packed {
        logic [FILL_W-1:0]  fill;
        logic [AVG_W-1:0]   avg_wait;
        logic [AVG_W-1:0]   avg_turn;
        logic [TIME_W-1:0]  waiting;
        logic [TIME_W-1:0]  completion;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [ID_W-1:0]    id;
    } out_beat_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // in_burst, in_priority
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // id, priority, burst, completion, waiting, avgs
    logic                   m_axis_tuser;   // overflow
    logic                   m_axis_tlast;

    job_t      loading_jobs[$];
    logic      loading_dropped;
    run_slot_t schedule_q[$];
    int        mismatches;
    int        park_request;
    bit        quiet;
    int        idle_cycles;

    priority_schedule_timing_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [AVG_W-1:0] fixed_mean(input longint unsigned total,
                                                   input int count);
        longint unsigned q;
        q = (total << FRAC_BITS) / count;
        return (q > longint'(AVG_MAX)) ? AVG_MAX : q[AVG_W-1:0];
    endfunction

    // Order the loaded batch by priority (stable) and queue its run slots.
    function automatic void schedule_batch();
        job_t              run_order[$];
        longint unsigned   clock_sum;
        longint unsigned   turn_sum;
        longint unsigned   wait_sum;
        logic [AVG_W-1:0]  avg_turn;
        logic [AVG_W-1:0]  avg_wait;
        run_slot_t         slot;
        int                j;
        int                n;
        n = loading_jobs.size();
        foreach (loading_jobs[i])
        begin
            j = run_order.size();
            while (j > 0 && run_order[j-1].prio > loading_jobs[i].prio)
                j--;
            run_order.insert(j, loading_jobs[i]);
        end
        clock_sum = 0;
        turn_sum = 0;
        wait_sum = 0;
        foreach (run_order[i])
        begin
            clock_sum = clock_sum + run_order[i].burst;
            if (clock_sum > longint'(TIME_MAX))
                clock_sum = longint'(TIME_MAX);
            turn_sum = turn_sum + clock_sum;
            if (turn_sum > longint'(TOT_MAX))
                turn_sum = longint'(TOT_MAX);
            wait_sum = wait_sum + (clock_sum - run_order[i].burst);
            if (wait_sum > longint'(TOT_MAX))
                wait_sum = longint'(TOT_MAX);
        end
        avg_turn = fixed_mean(turn_sum, n);
        avg_wait = fixed_mean(wait_sum, n);
        clock_sum = 0;
        foreach (run_order[i])
        begin
            clock_sum = clock_sum + run_order[i].burst;
            if (clock_sum > longint'(TIME_MAX))
                clock_sum = longint'(TIME_MAX);
            slot.id         = run_order[i].id;
            slot.prio       = run_order[i].prio;
            slot.burst      = run_order[i].burst;
            slot.completion = clock_sum[TIME_W-1:0];
            slot.waiting    = TIME_W'(clock_sum - run_order[i].burst);
            slot.avg_turn   = avg_turn;
            slot.avg_wait   = avg_wait;
            slot.dropped    = loading_dropped;
            slot.batch_end  = (i == n - 1);
            schedule_q.push_back(slot);
        end
    endfunction

    function automatic void load_job(input logic [BURST_W-1:0] burst,
                                     input logic [PRIO_W-1:0] prio, input logic last);
        job_t job;
        if (loading_jobs.size() < MAX_PROCS)
        begin
            job.burst = burst;
            job.prio  = prio;
            job.id    = ID_W'(loading_jobs.size() + 1);
            loading_jobs.push_back(job);
        end
        else
            loading_dropped = 1'b1;
        if (last)
        begin
            schedule_batch();
            loading_jobs.delete();
            loading_dropped = 1'b0;
        end
    endfunction

    task automatic send_job(input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                            input logic last);
        int gap;
        gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {prio, burst};
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        load_job(burst, prio, last);
    endtask

    task automatic test_single_jobs();
        send_job('0, '0, 1'b1);
        send_job('1, '1, 1'b1);
    endtask

    task automatic test_priority_ties();
        send_job(BURST_W'($urandom), 8'd5, 1'b0);
        send_job(BURST_W'($urandom), 8'd2, 1'b0);
        send_job(BURST_W'($urandom), 8'd5, 1'b0);
        send_job(BURST_W'($urandom), 8'd2, 1'b1);
    endtask

    // Largest sums, then one job past capacity carrying the last mark.
    task automatic test_full_batch_overflow();
        for (int k = 0; k <= MAX_PROCS; k++)
            send_job('1, PRIO_W'(MAX_PROCS - k), k == MAX_PROCS);
    endtask

    task automatic test_backlog_stall();
        quiet = 1'b1;
        park_request = PARK_CYCLES;
        for (int b = 0; b < 3; b++)
            for (int k = 0; k < MAX_PROCS; k++)
                send_job(BURST_W'($urandom), PRIO_W'($urandom_range(0, 7)),
                         k == MAX_PROCS - 1);
        quiet = 1'b0;
    endtask

    task automatic test_random_batches();
        int sent;
        int n;
        int prio_top;
        logic [BURST_W-1:0] burst;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:       n = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
                1, 2:    n = MAX_PROCS;
                default: n = $urandom_range(1, MAX_PROCS);
            endcase
            quiet = ($urandom_range(0, 4) == 0);
            prio_top = ($urandom_range(0, 1) == 0) ? 3 : 255;
            for (int k = 0; k < n; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       burst = '0;
                    1:       burst = '1;
                    2, 3:    burst = BURST_W'($urandom_range(0, 15));
                    default: burst = BURST_W'($urandom);
                endcase
                send_job(burst, PRIO_W'($urandom_range(0, prio_top)), k == n - 1);
            end
            sent += n;
        end
        quiet = 1'b0;
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        run_slot_t want;
        out_beat_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (schedule_q.size() == 0)
            begin
                $error("result beat with no scheduled job pending");
                mismatches++;
            end
            else
            begin
                want = schedule_q.pop_front();
                got  = out_beat_t'(m_axis_tdata);
                check_field("process_id", want.id, got.id);
                check_field("run_priority", want.prio, got.prio);
                check_field("run_burst", want.burst, got.burst);
                check_field("completion_time", want.completion, got.completion);
                check_field("waiting_time", want.waiting, got.waiting);
                check_field("avg_turnaround", want.avg_turn, got.avg_turn);
                check_field("avg_waiting", want.avg_wait, got.avg_wait);
                check_field("overflow", want.dropped, m_axis_tuser);
                check_field("end_of_run", want.batch_end, m_axis_tlast);
            end
        end
    end

    initial
    begin : receiver
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (park_request > 0)
            begin
                hold = park_request;
                park_request = 0;
            end
            else if (hold == 0 && !quiet && $urandom_range(0, 3) == 0)
                hold = pick_gap();
            if (hold > 0)
            begin
                m_axis_tready = 1'b0;
                hold--;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        loading_dropped = 1'b0;
        mismatches = 0;
        park_request = 0;
        quiet = 1'b0;
        idle_cycles = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_single_jobs();
        test_priority_ties();
        test_full_batch_overflow();
        test_backlog_stall();
        test_random_batches();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast = 1'b0;
        while (schedule_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
rtl/pst_pkg.sv
rtl/pst_ctrl.sv
rtl/pst_dpath.sv
rtl/priority_schedule_timing_top.sv
rtl/pst_checker.sv
sim/tb_top.sv
